FILE: rtl/tsmm_pkg.sv
`default_nettype none

package tsmm_pkg;

    localparam int SWITCH_W = 8;
    localparam int MASK_W   = 4;
    localparam int LED_W    = 8;
    localparam int MODE_W   = 3;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // layout modes
    localparam logic [MODE_W-1:0] MODE_QUAD       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SLIPS      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TURN_SLIP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SLIP_TURN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_XOVER      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_UNSET      = 3'd5;

    // item kinds
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_REFRESH = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_LAYOUT_MODE = 1'b0;

    // switch pair codes
    localparam logic [1:0] PAIR_SET_0 = 2'b01;
    localparam logic [1:0] PAIR_SET_1 = 2'b10;

    // double crossing switch byte codes and stored routes
    localparam logic [SWITCH_W-1:0] XOVER_CODE_0 = 8'h01;
    localparam logic [SWITCH_W-1:0] XOVER_CODE_1 = 8'h02;
    localparam logic [SWITCH_W-1:0] XOVER_CODE_2 = 8'h04;
    localparam logic [SWITCH_W-1:0] XOVER_ROUTE_0 = 8'd0;
    localparam logic [SWITCH_W-1:0] XOVER_ROUTE_1 = 8'd1;
    localparam logic [SWITCH_W-1:0] XOVER_ROUTE_2 = 8'd2;

    // servo pattern on refresh with no layout
    localparam logic [MASK_W-1:0] SERVO_IDLE_PATTERN = 4'b1010;

    typedef struct packed {
        logic                kind;
        logic [SWITCH_W-1:0] switch_bits;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] servo_valid;
        logic [MASK_W-1:0] servo_drive;
        logic [MASK_W-1:0] relay_valid;
        logic [MASK_W-1:0] relay_drive;
        logic [LED_W-1:0]  led_bits;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/tsmm_in_if.sv
`default_nettype none

interface tsmm_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [tsmm_pkg::SWITCH_W-1:0] switch_bits;

    modport source (output valid, kind, switch_bits, input ready);
    modport sink   (input valid, kind, switch_bits, output ready);
endinterface

`default_nettype wire

FILE: rtl/tsmm_out_if.sv
`default_nettype none

interface tsmm_out_if;
    logic                        valid;
    logic                        ready;
    logic [tsmm_pkg::MASK_W-1:0] servo_valid;
    logic [tsmm_pkg::MASK_W-1:0] servo_drive;
    logic [tsmm_pkg::MASK_W-1:0] relay_valid;
    logic [tsmm_pkg::MASK_W-1:0] relay_drive;
    logic [tsmm_pkg::LED_W-1:0]  led_bits;

    modport source (output valid, servo_valid, servo_drive, relay_valid, relay_drive,
                    led_bits, input ready);
    modport sink   (input valid, servo_valid, servo_drive, relay_valid, relay_drive,
                    led_bits, output ready);
endinterface

`default_nettype wire

FILE: rtl/turnout_servo_mode_mapper_core.sv
`default_nettype none

// Turnout servo/relay mapper.
// in_item carries one item per handshake: kind (sample or refresh) and the raw
// switch byte. A sample updates the stored turnout positions for the current
// layout mode; both kinds produce one result item on the result channel with
// servo and relay valid/drive masks and the LED pattern.
// The result for an accepted item is registered (result or skid register).
// Throughput: one item per cycle while in_item.ready is high; the decode is
// a single pass of logic into the result register and the position registers.
// Stall: a one-entry skid register catches an item accepted while the result
// register is held by the receiver; in_item.ready drops only while both the
// result and skid registers are full.
// The layout mode is to be written over the APB port (paddr[2] = 0) only while
// idle; the block does not enforce this. Reset: layout mode goes to unset,
// all stored positions to zero, both result registers empty.

module turnout_servo_mode_mapper_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tsmm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tsmm_pkg::DATA_W-1:0]   pwdata,
    output logic      [tsmm_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    tsmm_in_if.sink                            in_item,
    tsmm_out_if.source                         result
);

    logic [tsmm_pkg::MODE_W-1:0]   mode_reg;
    logic [tsmm_pkg::SWITCH_W-1:0] pos0_reg, pos0_next;
    logic [2:0]                    pos_bit_reg, pos_bit_next;   // positions 1..3
    logic                          out_valid_reg, skid_valid_reg;
    tsmm_pkg::out_item_t           out_reg, skid_reg, res;
    tsmm_pkg::in_item_t            item;
    logic                          in_fire, out_fire, cfg_write, refresh, a_nz;

    function automatic logic pair_bit(input logic [1:0] p, input logic cur);
        logic r;
        r = cur;
        if (p == tsmm_pkg::PAIR_SET_0)
        begin
            r = 1'b0;
        end
        else if (p == tsmm_pkg::PAIR_SET_1)
        begin
            r = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [tsmm_pkg::SWITCH_W-1:0] pair_byte(
        input logic [1:0] p, input logic [tsmm_pkg::SWITCH_W-1:0] cur);
        logic [tsmm_pkg::SWITCH_W-1:0] r;
        r = cur;
        if (p == tsmm_pkg::PAIR_SET_0)
        begin
            r = '0;
        end
        else if (p == tsmm_pkg::PAIR_SET_1)
        begin
            r = tsmm_pkg::SWITCH_W'(1);
        end
        return r;
    endfunction

    function automatic logic [1:0] led_pair(input logic nz);
        return nz ? tsmm_pkg::PAIR_SET_1 : tsmm_pkg::PAIR_SET_0;
    endfunction

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == tsmm_pkg::REG_LAYOUT_MODE);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == tsmm_pkg::REG_LAYOUT_MODE)
        begin
            prdata = {{(tsmm_pkg::DATA_W-tsmm_pkg::MODE_W){1'b0}}, mode_reg};
        end
    end

    // handshake
    assign item        = '{kind: in_item.kind, switch_bits: in_item.switch_bits};
    assign in_item.ready = !skid_valid_reg;
    assign in_fire     = in_item.valid && in_item.ready;
    assign out_fire    = out_valid_reg && result.ready;
    assign refresh     = (item.kind == tsmm_pkg::KIND_REFRESH);

    // position update
    always_comb
    begin
        pos0_next    = pos0_reg;
        pos_bit_next = pos_bit_reg;
        if (!refresh)
        begin
            unique case (mode_reg)
                tsmm_pkg::MODE_QUAD:
                begin
                    pos0_next       = pair_byte(item.switch_bits[1:0], pos0_reg);
                    pos_bit_next[0] = pair_bit(item.switch_bits[3:2], pos_bit_reg[0]);
                    pos_bit_next[1] = pair_bit(item.switch_bits[5:4], pos_bit_reg[1]);
                    pos_bit_next[2] = pair_bit(item.switch_bits[7:6], pos_bit_reg[2]);
                end
                tsmm_pkg::MODE_SLIPS:
                begin
                    pos0_next       = pair_byte(item.switch_bits[1:0], pos0_reg);
                    pos_bit_next[0] = pair_bit(item.switch_bits[3:2], pos_bit_reg[0]);
                end
                tsmm_pkg::MODE_TURN_SLIP:
                begin
                    pos0_next       = pair_byte(item.switch_bits[1:0], pos0_reg);
                    pos_bit_next[0] = pair_bit(item.switch_bits[3:2], pos_bit_reg[0]);
                    pos_bit_next[1] = pair_bit(item.switch_bits[7:6], pos_bit_reg[1]);
                end
                tsmm_pkg::MODE_SLIP_TURN:
                begin
                    pos0_next       = pair_byte(item.switch_bits[3:2], pos0_reg);
                    pos_bit_next[0] = pair_bit(item.switch_bits[5:4], pos_bit_reg[0]);
                    pos_bit_next[1] = pair_bit(item.switch_bits[7:6], pos_bit_reg[1]);
                end
                tsmm_pkg::MODE_XOVER:
                begin
                    if (item.switch_bits == tsmm_pkg::XOVER_CODE_0)
                    begin
                        pos0_next = tsmm_pkg::XOVER_ROUTE_0;
                    end
                    else if (item.switch_bits == tsmm_pkg::XOVER_CODE_1)
                    begin
                        pos0_next = tsmm_pkg::XOVER_ROUTE_1;
                    end
                    else if (item.switch_bits == tsmm_pkg::XOVER_CODE_2)
                    begin
                        pos0_next = tsmm_pkg::XOVER_ROUTE_2;
                    end
                end
                tsmm_pkg::MODE_UNSET:
                begin
                    pos0_next = item.switch_bits;
                end
                default:
                begin
                    pos0_next = pos0_reg;
                end
            endcase
        end
    end

    // drive masks and LEDs from the updated positions
    assign a_nz = |pos0_next;

    always_comb
    begin
        res = '0;
        unique case (mode_reg)
            tsmm_pkg::MODE_QUAD:
            begin
                res.servo_valid = '1;
                res.servo_drive = {pos_bit_next, a_nz};
                res.relay_valid = '1;
                res.relay_drive = {pos_bit_next, a_nz};
                res.led_bits    = {led_pair(pos_bit_next[2]), led_pair(pos_bit_next[1]),
                                   led_pair(pos_bit_next[0]), led_pair(a_nz)};
            end
            tsmm_pkg::MODE_SLIPS:
            begin
                res.servo_valid = '1;
                res.servo_drive = {pos_bit_next[0], pos_bit_next[0], a_nz, a_nz};
                res.relay_valid = 4'b0011;
                res.relay_drive = {2'b00, pos_bit_next[0], a_nz};
                res.led_bits    = {4'b0000, led_pair(pos_bit_next[0]), led_pair(a_nz)};
            end
            tsmm_pkg::MODE_TURN_SLIP:
            begin
                res.servo_valid = '1;
                res.servo_drive = {pos_bit_next[1], pos_bit_next[1], pos_bit_next[0], a_nz};
                res.relay_valid = 4'b0010;
                res.relay_drive = {2'b00, pos_bit_next[1], 1'b0};
                res.led_bits    = {led_pair(pos_bit_next[1]), 2'b00,
                                   led_pair(pos_bit_next[0]), led_pair(a_nz)};
            end
            tsmm_pkg::MODE_SLIP_TURN:
            begin
                res.servo_valid = '1;
                res.servo_drive = {pos_bit_next[1], pos_bit_next[0], a_nz, a_nz};
                res.relay_valid = 4'b0011;
                res.relay_drive = {2'b00, pos_bit_next[0], a_nz};
                res.led_bits    = {led_pair(pos_bit_next[1]), led_pair(pos_bit_next[0]),
                                   led_pair(a_nz), 2'b00};
            end
            tsmm_pkg::MODE_XOVER:
            begin
                res.led_bits = {6'b000000, led_pair(a_nz)};
                // a stored value other than the three routes drives nothing
                case (pos0_next)
                    tsmm_pkg::XOVER_ROUTE_0:
                    begin
                        res.servo_valid = '1;
                        res.relay_valid = 4'b0011;
                    end
                    tsmm_pkg::XOVER_ROUTE_1:
                    begin
                        res.servo_valid = '1;
                        res.servo_drive = 4'b1001;
                        res.relay_valid = 4'b0011;
                        res.relay_drive = 4'b0001;
                    end
                    tsmm_pkg::XOVER_ROUTE_2:
                    begin
                        res.servo_valid = '1;
                        res.servo_drive = 4'b0110;
                        res.relay_valid = 4'b0011;
                        res.relay_drive = 4'b0010;
                    end
                    default:
                    begin
                        res.servo_valid = '0;
                    end
                endcase
            end
            default:
            begin
                if (mode_reg == tsmm_pkg::MODE_UNSET)
                begin
                    res.led_bits = pos0_next;
                end
                if (refresh)
                begin
                    res.servo_valid = '1;
                    res.servo_drive = tsmm_pkg::SERVO_IDLE_PATTERN;
                end
            end
        endcase
    end

    // state, result register and skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= tsmm_pkg::MODE_UNSET;
            pos0_reg       <= '0;
            pos_bit_reg    <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                mode_reg <= pwdata[tsmm_pkg::MODE_W-1:0];
            end
            if (in_fire)
            begin
                pos0_reg    <= pos0_next;
                pos_bit_reg <= pos_bit_next;
            end
            if (skid_valid_reg)
            begin
                // drain the skid into the result register
                if (out_fire)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_fire)
            begin
                if (out_valid_reg && !result.ready)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !result.ready)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.servo_valid = out_reg.servo_valid;
    assign result.servo_drive = out_reg.servo_drive;
    assign result.relay_valid = out_reg.relay_valid;
    assign result.relay_drive = out_reg.relay_drive;
    assign result.led_bits    = out_reg.led_bits;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while result register empty");

    a_refresh_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && refresh) |=> ($stable(pos0_reg) && $stable(pos_bit_reg)))
        else $error("refresh item changed stored positions");

    a_drive_within_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (((out_reg.servo_drive & ~out_reg.servo_valid) == '0)
                           && ((out_reg.relay_drive & ~out_reg.relay_valid) == '0)))
        else $error("drive bit set without its valid bit");
`endif

endmodule

`default_nettype wire

FILE: tb/turnout_servo_mode_mapper_core_tb.sv
`default_nettype none

module turnout_servo_mode_mapper_core_tb;

    localparam int CYCLE_LIMIT       = 200000;
    localparam int HOLDOFF_CYCLES    = 60;
    localparam int ITEMS_PER_SETTING = 50;

    // mode codes the block does not define
    localparam logic [tsmm_pkg::MODE_W-1:0] MODE_UNDEF_6 = 3'd6;
    localparam logic [tsmm_pkg::MODE_W-1:0] MODE_UNDEF_7 = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [tsmm_pkg::ADDR_W-1:0] paddr;
    logic [tsmm_pkg::DATA_W-1:0] pwdata;
    logic [tsmm_pkg::DATA_W-1:0] prdata;
    logic pready;

    tsmm_in_if  switch_ch ();
    tsmm_out_if result_ch ();

    turnout_servo_mode_mapper_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_item (switch_ch),
        .result  (result_ch)
    );

    always #5 clk = ~clk;

    // shadow of the block's register and stored turnout positions
    logic [tsmm_pkg::MODE_W-1:0]   layout_mode;
    logic [tsmm_pkg::SWITCH_W-1:0] turnout_pos [4];

    tsmm_pkg::out_item_t pending_outputs [$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        holdoff_req = 1'b0;

    function automatic logic [tsmm_pkg::SWITCH_W-1:0] apply_pair(
        input logic [tsmm_pkg::SWITCH_W-1:0] old_pos, input logic [1:0] pair);
        if (pair == tsmm_pkg::PAIR_SET_0)
            return 8'd0;
        if (pair == tsmm_pkg::PAIR_SET_1)
            return 8'd1;
        return old_pos;
    endfunction

    function automatic logic [1:0] led_pair(input logic [tsmm_pkg::SWITCH_W-1:0] pos);
        return (pos != 8'd0) ? tsmm_pkg::PAIR_SET_1 : tsmm_pkg::PAIR_SET_0;
    endfunction

    // update the stored positions for one item and return the result it causes
    function automatic tsmm_pkg::out_item_t predict_turnout_outputs(
        input logic kind, input logic [tsmm_pkg::SWITCH_W-1:0] bits);
        tsmm_pkg::out_item_t o;
        logic [tsmm_pkg::MASK_W-1:0] sv_on;
        logic [tsmm_pkg::MASK_W-1:0] sv_val;
        logic [tsmm_pkg::MASK_W-1:0] rl_on;
        logic [tsmm_pkg::MASK_W-1:0] rl_val;
        logic a;
        logic b;
        logic c;
        o      = '0;
        sv_on  = '0;
        sv_val = '0;
        rl_on  = '0;
        rl_val = '0;
        if (kind == tsmm_pkg::KIND_SAMPLE)
        begin
            case (layout_mode)
                tsmm_pkg::MODE_QUAD:
                begin
                    for (int n = 0; n < 4; n++)
                        turnout_pos[n] = apply_pair(turnout_pos[n], bits[2*n +: 2]);
                end
                tsmm_pkg::MODE_SLIPS:
                begin
                    turnout_pos[0] = apply_pair(turnout_pos[0], bits[1:0]);
                    turnout_pos[1] = apply_pair(turnout_pos[1], bits[3:2]);
                end
                tsmm_pkg::MODE_TURN_SLIP:
                begin
                    turnout_pos[0] = apply_pair(turnout_pos[0], bits[1:0]);
                    turnout_pos[1] = apply_pair(turnout_pos[1], bits[3:2]);
                    turnout_pos[2] = apply_pair(turnout_pos[2], bits[7:6]);
                end
                tsmm_pkg::MODE_SLIP_TURN:
                begin
                    turnout_pos[0] = apply_pair(turnout_pos[0], bits[3:2]);
                    turnout_pos[1] = apply_pair(turnout_pos[1], bits[5:4]);
                    turnout_pos[2] = apply_pair(turnout_pos[2], bits[7:6]);
                end
                tsmm_pkg::MODE_XOVER:
                begin
                    if (bits == tsmm_pkg::XOVER_CODE_0)
                        turnout_pos[0] = tsmm_pkg::XOVER_ROUTE_0;
                    else if (bits == tsmm_pkg::XOVER_CODE_1)
                        turnout_pos[0] = tsmm_pkg::XOVER_ROUTE_1;
                    else if (bits == tsmm_pkg::XOVER_CODE_2)
                        turnout_pos[0] = tsmm_pkg::XOVER_ROUTE_2;
                end
                tsmm_pkg::MODE_UNSET: turnout_pos[0] = bits;
                default: ;
            endcase
        end

        a = (turnout_pos[0] != 8'd0);
        b = (turnout_pos[1] != 8'd0);
        c = (turnout_pos[2] != 8'd0);
        if (kind == tsmm_pkg::KIND_REFRESH || layout_mode <= tsmm_pkg::MODE_XOVER)
        begin
            case (layout_mode)
                tsmm_pkg::MODE_QUAD:
                begin
                    sv_on  = 4'hF;
                    sv_val = {turnout_pos[3] != 8'd0, c, b, a};
                    rl_on  = 4'hF;
                    rl_val = sv_val;
                end
                tsmm_pkg::MODE_SLIPS:
                begin
                    sv_on  = 4'hF;
                    sv_val = {b, b, a, a};
                    rl_on  = 4'b0011;
                    rl_val = {2'b00, b, a};
                end
                tsmm_pkg::MODE_TURN_SLIP:
                begin
                    sv_on  = 4'hF;
                    sv_val = {c, c, b, a};
                    rl_on  = 4'b0010;
                    rl_val = {2'b00, c, 1'b0};
                end
                tsmm_pkg::MODE_SLIP_TURN:
                begin
                    sv_on  = 4'hF;
                    sv_val = {c, b, a, a};
                    rl_on  = 4'b0011;
                    rl_val = {2'b00, b, a};
                end
                tsmm_pkg::MODE_XOVER:
                begin
                    // a value left over from unset mode drives nothing
                    if (turnout_pos[0] == tsmm_pkg::XOVER_ROUTE_0)
                    begin
                        sv_on = 4'hF;
                        rl_on = 4'b0011;
                    end
                    else if (turnout_pos[0] == tsmm_pkg::XOVER_ROUTE_1)
                    begin
                        sv_on  = 4'hF;
                        sv_val = 4'b1001;
                        rl_on  = 4'b0011;
                        rl_val = 4'b0001;
                    end
                    else if (turnout_pos[0] == tsmm_pkg::XOVER_ROUTE_2)
                    begin
                        sv_on  = 4'hF;
                        sv_val = 4'b0110;
                        rl_on  = 4'b0011;
                        rl_val = 4'b0010;
                    end
                end
                default:
                begin
                    sv_on  = 4'hF;
                    sv_val = tsmm_pkg::SERVO_IDLE_PATTERN;
                end
            endcase
        end
        o.servo_valid = sv_on;
        o.servo_drive = sv_val & sv_on;
        o.relay_valid = rl_on;
        o.relay_drive = rl_val & rl_on;

        case (layout_mode)
            tsmm_pkg::MODE_QUAD:
                o.led_bits = {led_pair(turnout_pos[3]), led_pair(turnout_pos[2]),
                              led_pair(turnout_pos[1]), led_pair(turnout_pos[0])};
            tsmm_pkg::MODE_SLIPS:
                o.led_bits = {4'b0000, led_pair(turnout_pos[1]), led_pair(turnout_pos[0])};
            tsmm_pkg::MODE_TURN_SLIP:
                o.led_bits = {led_pair(turnout_pos[2]), 2'b00,
                              led_pair(turnout_pos[1]), led_pair(turnout_pos[0])};
            tsmm_pkg::MODE_SLIP_TURN:
                o.led_bits = {led_pair(turnout_pos[2]), led_pair(turnout_pos[1]),
                              led_pair(turnout_pos[0]), 2'b00};
            tsmm_pkg::MODE_XOVER:
                o.led_bits = {6'b000000, led_pair(turnout_pos[0])};
            tsmm_pkg::MODE_UNSET:
                o.led_bits = turnout_pos[0];
            default:
                o.led_bits = 8'd0;
        endcase
        return o;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        tsmm_pkg::out_item_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                $display("%0t: result with none expected, expected nothing, got %h %h %h %h %h",
                         $time, result_ch.servo_valid, result_ch.servo_drive,
                         result_ch.relay_valid, result_ch.relay_drive, result_ch.led_bits);
                mismatches++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                check_field("servo_valid", 8'(want.servo_valid), 8'(result_ch.servo_valid));
                check_field("servo_drive", 8'(want.servo_drive), 8'(result_ch.servo_drive));
                check_field("relay_valid", 8'(want.relay_valid), 8'(result_ch.relay_valid));
                check_field("relay_drive", 8'(want.relay_drive), 8'(result_ch.relay_drive));
                check_field("led_bits", want.led_bits, result_ch.led_bits);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                holdoff_req = 1'b0;
            end
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // call on a rising edge; returns on the edge that accepted the item
    task automatic send_switch_item(input logic kind,
                                    input logic [tsmm_pkg::SWITCH_W-1:0] bits);
        while ($urandom_range(99) < send_idle_pct)
        begin
            switch_ch.valid <= 1'b0;
            @(posedge clk);
        end
        switch_ch.valid       <= 1'b1;
        switch_ch.kind        <= kind;
        switch_ch.switch_bits <= bits;
        do
            @(posedge clk);
        while (!switch_ch.ready);
        pending_outputs.push_back(predict_turnout_outputs(kind, bits));
    endtask

    task automatic drain_results();
        switch_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_layout_mode(input logic [tsmm_pkg::MODE_W-1:0] mode);
        logic [tsmm_pkg::DATA_W-1:0] readback;
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {tsmm_pkg::REG_LAYOUT_MODE, 2'b00};
        pwdata  <= tsmm_pkg::DATA_W'(mode);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        layout_mode = mode;
        // read it back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (readback[tsmm_pkg::MODE_W-1:0] !== mode)
        begin
            $display("%0t: layout_mode readback mismatch, expected %h, got %h",
                     $time, mode, readback[tsmm_pkg::MODE_W-1:0]);
            mismatches++;
        end
    endtask

    task automatic test_unset_after_reset();
        send_switch_item(tsmm_pkg::KIND_SAMPLE, 8'hFF);
        send_switch_item(tsmm_pkg::KIND_REFRESH, 8'h00);
        send_switch_item(tsmm_pkg::KIND_SAMPLE, 8'h00);
    endtask

    task automatic test_layout_modes();
        write_layout_mode(tsmm_pkg::MODE_QUAD);
        send_switch_item(tsmm_pkg::KIND_SAMPLE, 8'h99);
        send_switch_item(tsmm_pkg::KIND_SAMPLE, 8'h66);
        send_switch_item(tsmm_pkg::KIND_SAMPLE, 8'hFF);
        send_switch_item(tsmm_pkg::KIND_REFRESH, 8'h00);
        write_layout_mode(tsmm_pkg::MODE_SLIPS);
        send_switch_item(tsmm_pkg::KIND_SAMPLE, 8'h0A);
        send_switch_item(tsmm_pkg::KIND_SAMPLE, 8'h00);
        write_layout_mode(tsmm_pkg::MODE_TURN_SLIP);
        send_switch_item(tsmm_pkg::KIND_SAMPLE, 8'h86);
        send_switch_item(tsmm_pkg::KIND_REFRESH, 8'h5A);
        write_layout_mode(tsmm_pkg::MODE_SLIP_TURN);
        send_switch_item(tsmm_pkg::KIND_SAMPLE, 8'hA4);
        send_switch_item(tsmm_pkg::KIND_SAMPLE, 8'h58);
        write_layout_mode(tsmm_pkg::MODE_XOVER);
        send_switch_item(tsmm_pkg::KIND_SAMPLE, tsmm_pkg::XOVER_CODE_1);
        send_switch_item(tsmm_pkg::KIND_SAMPLE, tsmm_pkg::XOVER_CODE_2);
        send_switch_item(tsmm_pkg::KIND_SAMPLE, 8'h03);
        send_switch_item(tsmm_pkg::KIND_SAMPLE, tsmm_pkg::XOVER_CODE_0);
    endtask

    // a raw byte stored in unset mode is not a valid double crossing route
    task automatic test_stale_unset_route();
        write_layout_mode(tsmm_pkg::MODE_UNSET);
        send_switch_item(tsmm_pkg::KIND_SAMPLE, 8'h37);
        write_layout_mode(tsmm_pkg::MODE_XOVER);
        send_switch_item(tsmm_pkg::KIND_REFRESH, 8'h00);
        send_switch_item(tsmm_pkg::KIND_SAMPLE, 8'h80);
    endtask

    task automatic test_undefined_modes();
        write_layout_mode(MODE_UNDEF_6);
        send_switch_item(tsmm_pkg::KIND_SAMPLE, 8'h55);
        send_switch_item(tsmm_pkg::KIND_REFRESH, 8'hAA);
        write_layout_mode(MODE_UNDEF_7);
        send_switch_item(tsmm_pkg::KIND_REFRESH, 8'hFF);
    endtask

    task automatic test_receiver_holdoff();
        write_layout_mode(tsmm_pkg::MODE_QUAD);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holdoff_req   = 1'b1;
        for (int i = 0; i < 30; i++)
            send_switch_item(($urandom_range(3) == 0) ? tsmm_pkg::KIND_REFRESH
                                                      : tsmm_pkg::KIND_SAMPLE,
                             8'($urandom_range(255)));
        drain_results();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        logic [tsmm_pkg::SWITCH_W-1:0] bits;
        logic                          kind;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % ITEMS_PER_SETTING == 0)
            begin
                if (i / ITEMS_PER_SETTING < 8)
                    write_layout_mode(tsmm_pkg::MODE_W'(i / ITEMS_PER_SETTING));
                else
                    write_layout_mode(tsmm_pkg::MODE_W'($urandom_range(7)));
            end
            kind = ($urandom_range(3) == 0) ? tsmm_pkg::KIND_REFRESH : tsmm_pkg::KIND_SAMPLE;
            bits = 8'($urandom_range(255));
            // favor the route codes so the double crossing moves often
            if (layout_mode == tsmm_pkg::MODE_XOVER && $urandom_range(1) == 0)
            begin
                case ($urandom_range(2))
                    0: bits = tsmm_pkg::XOVER_CODE_0;
                    1: bits = tsmm_pkg::XOVER_CODE_1;
                    default: bits = tsmm_pkg::XOVER_CODE_2;
                endcase
            end
            send_switch_item(kind, bits);
        end
        drain_results();
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        switch_ch.valid       <= 1'b0;
        switch_ch.kind        <= tsmm_pkg::KIND_SAMPLE;
        switch_ch.switch_bits <= '0;
        layout_mode = tsmm_pkg::MODE_UNSET;
        for (int n = 0; n < 4; n++)
            turnout_pos[n] = 8'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unset_after_reset();
        test_layout_modes();
        test_stale_unset_route();
        test_undefined_modes();
        test_receiver_holdoff();
        test_random_traffic(18, 71, 450);
        test_random_traffic(71, 18, 450);
        test_random_traffic(0, 0, 450);

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

FILE: turnout_servo_mode_mapper_core.f
rtl/tsmm_pkg.sv
rtl/tsmm_in_if.sv
rtl/tsmm_out_if.sv
rtl/turnout_servo_mode_mapper_core.sv
tb/turnout_servo_mode_mapper_core_tb.sv
